// ===== rtl/m3i_pkg.sv =====
// Shared widths, types and constants for the 3x3 matrix inverse pipeline.
`timescale 1ns / 1ps
`default_nettype none
package m3i_pkg;
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ADJ_W   = PROD_W + 1;
  localparam int DPROD_W = ELEM_W + ADJ_W;
  localparam int DET_W   = DPROD_W;
  localparam int MAG_W   = ADJ_W - 1;
  localparam int FRAC_SH = 24;
  localparam int NUM_W   = MAG_W + FRAC_SH;
  localparam int DEN_W   = DET_W - 1;
  localparam int QUO_W   = 32;
  localparam int LANES   = 9;
  localparam int NPROD   = 2 * LANES;

  localparam logic [QUO_W-1:0] POS_MAX = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] NEG_MIN = {1'b1, {(QUO_W-1){1'b0}}};

  typedef struct packed {
    logic valid;
    logic singular;
  } ctl_t;
endpackage
`default_nettype wire

// ===== rtl/m3i_div.sv =====
// Nine-lane pipelined restoring divider, one quotient bit per stage, with saturation.
`timescale 1ns / 1ps
`default_nettype none
module m3i_div (
  input  logic                          clk,
  input  logic                          rst,
  input  m3i_pkg::ctl_t                 ctl_in,
  input  logic [m3i_pkg::DEN_W-1:0]     den,
  input  logic [m3i_pkg::NUM_W-1:0]     num [m3i_pkg::LANES],
  input  logic [m3i_pkg::LANES-1:0]     neg,
  input  logic [m3i_pkg::LANES-1:0]     ovf,
  output m3i_pkg::ctl_t                 ctl_out,
  output logic [m3i_pkg::QUO_W-1:0]     quo [m3i_pkg::LANES]
);
  localparam int ST = m3i_pkg::QUO_W;
  localparam int TW = m3i_pkg::DEN_W + m3i_pkg::QUO_W;
  localparam int NL = m3i_pkg::LANES;

  m3i_pkg::ctl_t                 ctl     [1:ST];
  logic [m3i_pkg::DEN_W-1:0]     den_s   [1:ST];
  logic [m3i_pkg::NUM_W-1:0]     rem     [1:ST][NL];
  logic [m3i_pkg::QUO_W-1:0]     qb      [1:ST][NL];
  logic [NL-1:0]                 neg_s   [1:ST];
  logic [NL-1:0]                 ovf_s   [1:ST];

  m3i_pkg::ctl_t                 ctl_src [0:ST-1];
  logic [m3i_pkg::DEN_W-1:0]     den_src [0:ST-1];
  logic [m3i_pkg::NUM_W-1:0]     rem_src [0:ST-1][NL];
  logic [m3i_pkg::QUO_W-1:0]     qb_src  [0:ST-1][NL];
  logic [NL-1:0]                 neg_src [0:ST-1];
  logic [NL-1:0]                 ovf_src [0:ST-1];
  logic [m3i_pkg::NUM_W-1:0]     rem_next [0:ST-1][NL];
  logic [m3i_pkg::QUO_W-1:0]     qb_next  [0:ST-1][NL];

  always_comb begin
    ctl_src[0] = ctl_in;
    den_src[0] = den;
    neg_src[0] = neg;
    ovf_src[0] = ovf;
    for (int l = 0; l < NL; l++) begin
      rem_src[0][l] = num[l];
      qb_src[0][l]  = '0;
    end
    for (int k = 1; k < ST; k++) begin
      ctl_src[k] = ctl[k];
      den_src[k] = den_s[k];
      neg_src[k] = neg_s[k];
      ovf_src[k] = ovf_s[k];
      for (int l = 0; l < NL; l++) begin
        rem_src[k][l] = rem[k][l];
        qb_src[k][l]  = qb[k][l];
      end
    end
  end

  always_comb begin
    logic [TW-1:0] sh;
    logic [TW:0]   diff;
    for (int k = 0; k < ST; k++) begin
      for (int l = 0; l < NL; l++) begin
        sh   = TW'(den_src[k]) << (ST - 1 - k);
        diff = {1'b0, TW'(rem_src[k][l])} - {1'b0, sh};
        rem_next[k][l] = diff[TW] ? rem_src[k][l] : diff[m3i_pkg::NUM_W-1:0];
        qb_next[k][l]  = {qb_src[k][l][m3i_pkg::QUO_W-2:0], ~diff[TW]};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= ST; k++) begin
      if (rst) begin
        ctl[k] <= '0;
      end else begin
        ctl[k] <= ctl_src[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= ST; k++) begin
      den_s[k] <= den_src[k-1];
      neg_s[k] <= neg_src[k-1];
      ovf_s[k] <= ovf_src[k-1];
      for (int l = 0; l < NL; l++) begin
        rem[k][l] <= rem_next[k-1][l];
        qb[k][l]  <= qb_next[k-1][l];
      end
    end
  end

  assign ctl_out = ctl[ST];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (neg_s[ST][l]) begin
        if (ovf_s[ST][l] || (qb[ST][l] > m3i_pkg::NEG_MIN)) begin
          quo[l] = m3i_pkg::NEG_MIN;
        end else begin
          quo[l] = ~qb[ST][l] + 1'b1;
        end
      end else begin
        if (ovf_s[ST][l] || qb[ST][l][m3i_pkg::QUO_W-1]) begin
          quo[l] = m3i_pkg::POS_MAX;
        end else begin
          quo[l] = qb[ST][l];
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/matrix3x3_inverse.sv =====
// Top level of the pipelined 3x3 matrix inverse by the adjugate method.
// Usage:
//   Drive a11..a33 (signed Q8.8) and pulse start; a transaction is taken at
//   each rising edge with start high and busy low. busy is always low, so a
//   new matrix may enter on every cycle.
//   Results b11..b33 (signed Q16.16, truncated toward zero, saturated) and
//   singular appear with done high for exactly one cycle, in input order.
//   A zero determinant gives singular high and all elements zero.
// Throughput: one matrix per cycle. Pipeline: input capture, cofactor
//   products, cofactor sums, determinant products, determinant sum,
//   magnitudes and the range check, then 32 divider stages that each
//   resolve one quotient bit in all nine lanes, then the output register.
// Reset: synchronous rst clears every valid bit; transactions in flight are
//   dropped and done stays low until new transactions arrive.
// The receiver cannot stall; each result is offered once and never held.
`timescale 1ns / 1ps
`default_nettype none
module matrix3x3_inverse (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] a11,
  input  logic signed [15:0] a12,
  input  logic signed [15:0] a13,
  input  logic signed [15:0] a21,
  input  logic signed [15:0] a22,
  input  logic signed [15:0] a23,
  input  logic signed [15:0] a31,
  input  logic signed [15:0] a32,
  input  logic signed [15:0] a33,
  output logic               done,
  output logic signed [31:0] b11,
  output logic signed [31:0] b12,
  output logic signed [31:0] b13,
  output logic signed [31:0] b21,
  output logic signed [31:0] b22,
  output logic signed [31:0] b23,
  output logic signed [31:0] b31,
  output logic signed [31:0] b32,
  output logic signed [31:0] b33,
  output logic               singular
);
  localparam int NL = m3i_pkg::LANES;
  localparam int NP = m3i_pkg::NPROD;
  localparam int TW = m3i_pkg::DEN_W + m3i_pkg::QUO_W;
  localparam int unsigned OPA [NP] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int unsigned OPB [NP] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

  logic                                  v0, v1, v2, v3, v4;
  logic signed [m3i_pkg::ELEM_W-1:0]     x0 [NL];
  logic signed [m3i_pkg::ELEM_W-1:0]     x1 [3];
  logic signed [m3i_pkg::ELEM_W-1:0]     x2 [3];
  logic signed [m3i_pkg::PROD_W-1:0]     prod [NP];
  logic signed [m3i_pkg::ADJ_W-1:0]      adj2 [NL];
  logic signed [m3i_pkg::ADJ_W-1:0]      adj3 [NL];
  logic signed [m3i_pkg::ADJ_W-1:0]      adj4 [NL];
  logic signed [m3i_pkg::DPROD_W-1:0]    dp [3];
  logic signed [m3i_pkg::DET_W-1:0]      det4;
  logic signed [m3i_pkg::ADJ_W-1:0]      adj_neg [NL];
  logic signed [m3i_pkg::DET_W-1:0]      det_neg;

  m3i_pkg::ctl_t                         ctl5, ctl6, ctl_out;
  logic [m3i_pkg::NUM_W-1:0]             num5 [NL];
  logic [m3i_pkg::NUM_W-1:0]             num6 [NL];
  logic [NL-1:0]                         neg5, neg6, ovf6;
  logic [m3i_pkg::DEN_W-1:0]             den5, den6;
  logic [m3i_pkg::QUO_W-1:0]             quo [NL];
  logic [m3i_pkg::QUO_W-1:0]             bq [NL];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      ctl5 <= '0;
      ctl6 <= '0;
      done <= 1'b0;
    end else begin
      v0   <= start && !busy;
      v1   <= v0;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      ctl5 <= '{valid: v4, singular: (det4 == '0)};
      ctl6 <= ctl5;
      done <= ctl_out.valid;
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      adj_neg[l] = -adj4[l];
    end
    det_neg = -det4;
  end

  always_ff @(posedge clk) begin
    x0[0] <= a11;
    x0[1] <= a12;
    x0[2] <= a13;
    x0[3] <= a21;
    x0[4] <= a22;
    x0[5] <= a23;
    x0[6] <= a31;
    x0[7] <= a32;
    x0[8] <= a33;
    for (int p = 0; p < NP; p++) begin
      prod[p] <= x0[OPA[p]] * x0[OPB[p]];
    end
    for (int r = 0; r < 3; r++) begin
      x1[r] <= x0[r];
      x2[r] <= x1[r];
      dp[r] <= x2[r] * adj2[3*r];
    end
    for (int l = 0; l < NL; l++) begin
      adj2[l] <= m3i_pkg::ADJ_W'(prod[2*l]) - m3i_pkg::ADJ_W'(prod[2*l+1]);
      adj3[l] <= adj2[l];
      adj4[l] <= adj3[l];
      num5[l] <= {(adj4[l][m3i_pkg::ADJ_W-1] ? adj_neg[l][m3i_pkg::MAG_W-1:0]
                                             : adj4[l][m3i_pkg::MAG_W-1:0]),
                  {m3i_pkg::FRAC_SH{1'b0}}};
      neg5[l] <= adj4[l][m3i_pkg::ADJ_W-1] ^ det4[m3i_pkg::DET_W-1];
      num6[l] <= num5[l];
      ovf6[l] <= TW'(num5[l]) >= {den5, {m3i_pkg::QUO_W{1'b0}}};
    end
    det4 <= dp[0] + dp[1] + dp[2];
    den5 <= det4[m3i_pkg::DET_W-1] ? det_neg[m3i_pkg::DEN_W-1:0]
                                   : det4[m3i_pkg::DEN_W-1:0];
    den6 <= den5;
    neg6 <= neg5;
    singular <= ctl_out.singular;
    for (int l = 0; l < NL; l++) begin
      bq[l] <= ctl_out.singular ? '0 : quo[l];
    end
  end

  m3i_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl6),
    .den     (den6),
    .num     (num6),
    .neg     (neg6),
    .ovf     (ovf6),
    .ctl_out (ctl_out),
    .quo     (quo)
  );

  assign b11 = bq[0];
  assign b12 = bq[1];
  assign b13 = bq[2];
  assign b21 = bq[3];
  assign b22 = bq[4];
  assign b23 = bq[5];
  assign b31 = bq[6];
  assign b32 = bq[7];
  assign b33 = bq[8];

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##40 done)
    else $error("transaction did not complete after fixed latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 40))
    else $error("result without matching transaction");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && singular) |-> (b11 == 0 && b12 == 0 && b13 == 0 && b21 == 0 &&
                            b22 == 0 && b23 == 0 && b31 == 0 && b32 == 0 && b33 == 0))
    else $error("singular result carries nonzero elements");
endmodule
`default_nettype wire

// ===== bench/tb_matrix3x3_inverse.sv =====
// Self-checking testbench for matrix3x3_inverse: directed and random matrices, predicted results.
`timescale 1ns / 1ps
module tb_matrix3x3_inverse;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] a11 = '0, a12 = '0, a13 = '0, a21 = '0, a22 = '0, a23 = '0;
  logic signed [15:0] a31 = '0, a32 = '0, a33 = '0;
  logic done;
  logic signed [31:0] b11, b12, b13, b21, b22, b23, b31, b32, b33;
  logic singular;

  typedef struct packed {
    logic [8:0][31:0] elem;
    logic sing;
  } inverse_t;

  inverse_t inverse_q[$];
  int mismatches = 0;
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 200000;

  matrix3x3_inverse i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a11(a11), .a12(a12), .a13(a13), .a21(a21), .a22(a22), .a23(a23),
    .a31(a31), .a32(a32), .a33(a33),
    .done(done), .b11(b11), .b12(b12), .b13(b13), .b21(b21), .b22(b22), .b23(b23),
    .b31(b31), .b32(b32), .b33(b33), .singular(singular)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] quotient_sat(longint c, longint d);
    longint q;
    q = (c * 64'sd16777216) / d;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic inverse_t predict_inverse(logic signed [8:0][15:0] m);
    longint e[9];
    longint adj[9];
    longint det;
    inverse_t r;
    for (int i = 0; i < 9; i++) e[i] = longint'($signed(m[i]));
    adj[0] = e[4] * e[8] - e[5] * e[7];
    adj[1] = e[2] * e[7] - e[1] * e[8];
    adj[2] = e[1] * e[5] - e[2] * e[4];
    adj[3] = e[5] * e[6] - e[3] * e[8];
    adj[4] = e[0] * e[8] - e[2] * e[6];
    adj[5] = e[2] * e[3] - e[0] * e[5];
    adj[6] = e[3] * e[7] - e[4] * e[6];
    adj[7] = e[1] * e[6] - e[0] * e[7];
    adj[8] = e[0] * e[4] - e[1] * e[3];
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    r = '0;
    if (det == 0) begin
      r.sing = 1'b1;
    end else begin
      for (int i = 0; i < 9; i++) r.elem[i] = quotient_sat(adj[i], det);
    end
    return r;
  endfunction

  // m[0]=a11 ... m[8]=a33
  task automatic send_matrix(logic signed [8:0][15:0] m);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    {a33, a32, a31, a23, a22, a21, a13, a12, a11} <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    inverse_q.push_back(predict_inverse(m));
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 1024)) - 512);
      3: return 16'($signed($urandom_range(0, 8)) - 4) << 8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [8:0][15:0] m;
    m = '0; send_matrix(m);
    m = '0; m[0] = 16'h0100; m[4] = 16'h0100; m[8] = 16'h0100; send_matrix(m);
    m = '0; m[0] = 16'h0002; m[4] = 16'h0001; m[8] = 16'h0001; send_matrix(m);
    m = '0; m[0] = 16'h0001; m[4] = 16'h0001; m[8] = 16'h0001; send_matrix(m);
    m = '0; m[0] = 16'hffff; m[4] = 16'h0001; m[8] = 16'h0001; send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = 16'h8000;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = 16'h7fff;
    send_matrix(m);
    m = '0; m[0] = 16'h8000; m[4] = 16'h8000; m[8] = 16'h8000; send_matrix(m);
    m = '0; m[0] = 16'h7fff; m[4] = 16'h7fff; m[8] = 16'h7fff; send_matrix(m);
    m = '0; m[0] = 16'h8000; m[4] = 16'h7fff; m[8] = 16'h8000; send_matrix(m);
    m = '0; m[2] = 16'h0100; m[4] = 16'h0200; m[6] = 16'hfd00; send_matrix(m);
    m = '0; m[0] = 16'h0100; m[1] = 16'h0200; m[3] = 16'h0200; m[4] = 16'h0400;
    m[8] = 16'h0100; send_matrix(m);
    m = '0; m[0] = 16'h8000; m[1] = 16'h7fff; m[3] = 16'h7fff; m[4] = 16'h8000;
    m[8] = 16'h0001; send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = 16'(i + 1) << 8;
    send_matrix(m);
  endtask

  task automatic test_random();
    logic signed [8:0][15:0] m;
    for (int n = 0; n < 536; n++) begin
      for (int i = 0; i < 9; i++) m[i] = rand_elem();
      if ($urandom_range(0, 9) == 0) m[6 + $urandom_range(0, 2)] = 16'h0;
      if ($urandom_range(0, 11) == 0) begin
        for (int i = 0; i < 3; i++) m[3 + i] = m[i];
      end
      send_matrix(m);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      inverse_t got, want;
      got.elem = {b33, b32, b31, b23, b22, b21, b13, b12, b11};
      got.sing = singular;
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %h", got);
      end else begin
        want = inverse_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got.elem[i] !== want.elem[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("b%0d%0d: expected %h actual %h", i / 3 + 1, i % 3 + 1,
                       want.elem[i], got.elem[i]);
          end
        end
        if (got.sing !== want.sing) begin
          mismatches++;
          if (mismatches <= 10)
            $display("singular: expected %b actual %b", want.sing, got.sing);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_matrix3x3_inverse NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    start <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_matrix3x3_inverse OK");
    end else begin
      $display("tb_matrix3x3_inverse NOT OK");
    end
    $finish;
  end
endmodule
